### rtl/rrtq_pkg.sv
`timescale 1ns / 1ps

package rrtq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 128;
    localparam int HANDLE_W            = 16;
    localparam int ID_W                = 8;
    localparam int COUNT_W             = 8;
    localparam int S_TDATA_W           = 32;
    localparam int M_TDATA_W           = 56;

    localparam logic [ID_W-1:0] FIRST_ID_RESET = 8'd1;

    typedef enum logic [1:0] {
        CMD_ADD     = 2'd0,
        CMD_PREEMPT = 2'd1,
        CMD_EXIT    = 2'd2,
        CMD_KILL    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [ID_W-1:0]     id;
    } t_entry;

    // last member sits in the lowest bits
    typedef struct packed {
        logic [COUNT_W-1:0]  task_count;
        logic [HANDLE_W-1:0] kill_handle;
        logic [ID_W-1:0]     assigned_id;
        logic [HANDLE_W-1:0] running_handle;
        logic                running_valid;
        t_status             status;
    } t_result;

endpackage

### rtl/rrtq_mem.sv
`timescale 1ns / 1ps

module rrtq_mem #(
    parameter int DEPTH = rrtq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  rrtq_pkg::t_entry i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output rrtq_pkg::t_entry o_rdata
);

    rrtq_pkg::t_entry r_mem [DEPTH];
    rrtq_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/rrtq_ctrl.sv
`timescale 1ns / 1ps

module rrtq_ctrl #(
    parameter int DEPTH = rrtq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rrtq_pkg::ID_W-1:0]     i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  rrtq_pkg::t_cmd                i_cmd,
    input  logic [rrtq_pkg::HANDLE_W-1:0] i_handle,
    input  logic [rrtq_pkg::ID_W-1:0]     i_task_id,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output rrtq_pkg::t_result             o_res,
    output logic                          o_mem_we,
    output logic [AW-1:0]                 o_mem_waddr,
    output rrtq_pkg::t_entry              o_mem_wdata,
    output logic                          o_mem_re,
    output logic [AW-1:0]                 o_mem_raddr,
    input  rrtq_pkg::t_entry              i_mem_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROT,
        S_SCAN,
        S_RDF,
        S_WAIT,
        S_DONE
    } t_state;

    function automatic logic [AW-1:0] f_wrap(input logic [AW-1:0] p);
        f_wrap = (p == AW'(DEPTH - 1)) ? '0 : AW'(p + 1'b1);
    endfunction

    t_state                        r_state, n_state;
    logic [AW-1:0]                 r_head, n_head;
    logic [AW-1:0]                 r_tail, n_tail;
    logic [CW-1:0]                 r_occ, n_occ;
    logic [rrtq_pkg::ID_W-1:0]     r_next_id, n_next_id;
    logic                          r_pending, n_pending;
    rrtq_pkg::t_cmd                r_cmd, n_cmd;
    logic [rrtq_pkg::HANDLE_W-1:0] r_handle, n_handle;
    logic [rrtq_pkg::ID_W-1:0]     r_tid, n_tid;
    logic [AW-1:0]                 r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]                 r_iss, n_iss;
    logic [CW-1:0]                 r_proc, n_proc;
    logic                          r_rvld, n_rvld;
    logic                          r_found, n_found;
    rrtq_pkg::t_result             r_res, n_res;

    logic [CW+7:0] w_occ_ext;
    logic          w_last;

    assign w_occ_ext = {8'd0, r_occ};
    assign w_last    = (r_proc == CW'(r_occ - 1'b1));

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_occ       = r_occ;
        n_next_id   = r_next_id;
        n_pending   = r_pending;
        n_cmd       = r_cmd;
        n_handle    = r_handle;
        n_tid       = r_tid;
        n_rd_ptr    = r_rd_ptr;
        n_iss       = r_iss;
        n_proc      = r_proc;
        n_rvld      = r_rvld;
        n_found     = r_found;
        n_res       = r_res;
        o_mem_we    = 1'b0;
        o_mem_waddr = f_wrap(r_tail);
        o_mem_wdata = i_mem_rdata;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_head;

        if (i_cfg_we) begin
            n_next_id = i_cfg_wdata;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd      = i_cmd;
                    n_handle   = i_handle;
                    n_tid      = i_task_id;
                    n_res      = '0;
                    n_res.status = rrtq_pkg::ST_OK;
                    n_rd_ptr   = r_head;
                    n_iss      = '0;
                    n_proc     = '0;
                    n_rvld     = 1'b0;
                    n_found    = 1'b0;
                    n_state    = S_RDF;
                    case (i_cmd)
                        rrtq_pkg::CMD_ADD: begin
                            if (r_occ == CW'(DEPTH)) begin
                                n_res.status = rrtq_pkg::ST_FULL;
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_wdata = '{handle: i_handle, id: r_next_id};
                                n_tail      = f_wrap(r_tail);
                                n_occ       = CW'(r_occ + 1'b1);
                                n_next_id   = r_next_id + 1'b1;
                                n_res.assigned_id = r_next_id;
                            end
                        end
                        rrtq_pkg::CMD_PREEMPT: begin
                            if (r_occ == '0) begin
                                n_res.status = rrtq_pkg::ST_EMPTY;
                            end else begin
                                o_mem_re = 1'b1;
                                n_state  = S_ROT;
                            end
                        end
                        rrtq_pkg::CMD_EXIT: begin
                            if (r_occ == '0) begin
                                n_res.status = rrtq_pkg::ST_EMPTY;
                            end else if (!r_pending) begin
                                n_head = f_wrap(r_head);
                                n_occ  = CW'(r_occ - 1'b1);
                            end else begin
                                n_pending = 1'b0;
                                n_state   = S_SCAN;
                            end
                        end
                        rrtq_pkg::CMD_KILL: begin
                            if (r_occ == '0) begin
                                n_res.status = rrtq_pkg::ST_NOTFOUND;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_RDF;
                        end
                    endcase
                end
            end
            S_ROT: begin
                o_mem_we = 1'b1;
                n_tail   = f_wrap(r_tail);
                n_head   = f_wrap(r_head);
                n_state  = S_RDF;
            end
            S_SCAN: begin
                // reads stream one per cycle; a write of a rotated entry never
                // lands on a slot still to be read
                n_rvld = 1'b0;
                if (r_iss < r_occ) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_rd_ptr;
                    n_rd_ptr    = f_wrap(r_rd_ptr);
                    n_iss       = CW'(r_iss + 1'b1);
                    n_rvld      = 1'b1;
                end
                if (r_rvld) begin
                    n_proc = CW'(r_proc + 1'b1);
                    if (r_cmd == rrtq_pkg::CMD_KILL) begin
                        if (i_mem_rdata.id == r_tid) begin
                            n_found = 1'b1;
                            n_res.kill_handle = i_mem_rdata.handle;
                        end
                        if (w_last) begin
                            if (n_found) begin
                                n_pending = 1'b1;
                            end else begin
                                n_res.status = rrtq_pkg::ST_NOTFOUND;
                            end
                            n_state = S_RDF;
                        end
                    end else begin
                        if (i_mem_rdata.handle == r_handle) begin
                            n_head  = f_wrap(r_head);
                            n_occ   = CW'(r_occ - 1'b1);
                            n_state = S_RDF;
                        end else begin
                            o_mem_we = 1'b1;
                            n_tail   = f_wrap(r_tail);
                            n_head   = f_wrap(r_head);
                            if (w_last) begin
                                n_res.status = rrtq_pkg::ST_NOTFOUND;
                                n_state      = S_RDF;
                            end
                        end
                    end
                end
            end
            S_RDF: begin
                n_res.task_count = w_occ_ext[7:0];
                if (r_occ == '0) begin
                    n_res.running_valid  = 1'b0;
                    n_res.running_handle = '0;
                    n_state = S_DONE;
                end else begin
                    o_mem_re = 1'b1;
                    n_state  = S_WAIT;
                end
            end
            S_WAIT: begin
                n_res.running_valid  = 1'b1;
                n_res.running_handle = i_mem_rdata.handle;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_tail    <= AW'(DEPTH - 1);
            r_occ     <= '0;
            r_next_id <= rrtq_pkg::FIRST_ID_RESET;
            r_pending <= 1'b0;
            r_rvld    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_occ     <= n_occ;
            r_next_id <= n_next_id;
            r_pending <= n_pending;
            r_rvld    <= n_rvld;
        end
        r_cmd    <= n_cmd;
        r_handle <= n_handle;
        r_tid    <= n_tid;
        r_rd_ptr <= n_rd_ptr;
        r_iss    <= n_iss;
        r_proc   <= n_proc;
        r_found  <= n_found;
        r_res    <= n_res;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

### rtl/round_robin_task_queue_core.sv
// Round-robin ready queue of tasks (handle + id) kept in a circular buffer.
// Input stream (s_axis): one command per transfer: add, preempt, exit, kill.
// Output stream (m_axis): exactly one result per command, in order.
// Config: i_cfg_we/i_cfg_wdata load the first task id into the id counter;
// write only while the block is idle.
// Path from accept to m_axis_tvalid: add, plain exit and add to a full
// queue go through S_RDF and S_WAIT (front entry read) to S_DONE; preempt
// first rotates the front entry in S_ROT; S_WAIT is skipped when the queue
// is empty after the command. Kill, and exit while a kill is pending, first
// walk the queue through the memory read port at one entry per cycle.
// One command is worked on at a time; s_axis_tready rises again once the
// result moves into the output register.
// Reset clears head, count and the pending mark, sets tail to the last slot
// and sets the id counter to 1; the queue memory needs no clearing.
// When the receiver stalls, the result waits in the output register; one
// more command may run and then holds until that register drains.
`timescale 1ns / 1ps

module round_robin_task_queue_core #(
    parameter int QUEUE_DEPTH = rrtq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rrtq_pkg::ID_W-1:0]      i_cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // command[1:0], handle[17:2], task_id[25:18], zero[31:26]
    input  logic [rrtq_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // status[1:0], running_valid[2], running_handle[18:3], assigned_id[26:19],
    // kill_handle[42:27], task_count[50:43], zero[55:51]
    output logic [rrtq_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic              w_res_valid;
    logic              w_res_ready;
    rrtq_pkg::t_result w_res;
    logic              w_mem_we;
    logic [AW-1:0]     w_mem_waddr;
    rrtq_pkg::t_entry  w_mem_wdata;
    logic              w_mem_re;
    logic [AW-1:0]     w_mem_raddr;
    rrtq_pkg::t_entry  w_mem_rdata;

    logic              r_out_valid;
    rrtq_pkg::t_result r_out;

    rrtq_ctrl #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_cmd       (rrtq_pkg::t_cmd'(s_axis_tdata[1:0])),
        .i_handle    (s_axis_tdata[17:2]),
        .i_task_id   (s_axis_tdata[25:18]),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_re    (w_mem_re),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    rrtq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(rrtq_pkg::M_TDATA_W - $bits(rrtq_pkg::t_result)){1'b0}}, r_out};

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_res_valid)
        else $error("input ready while a result is pending");

    a_running_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (QUEUE_DEPTH > 255) ||
            (r_out.running_valid == (r_out.task_count != 8'd0)))
        else $error("running flag disagrees with task count");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out.status != rrtq_pkg::ST_OK) |->
            (r_out.kill_handle == '0 && r_out.assigned_id == '0))
        else $error("failed command reports an id or handle");

    a_empty_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !r_out.running_valid) |-> (r_out.running_handle == '0))
        else $error("empty queue reports a running handle");

endmodule

### bench/task_queue_checker.sv
`timescale 1ns / 1ps

module task_queue_checker #(
    parameter int DEPTH = rrtq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rrtq_pkg::ID_W-1:0]      i_cfg_wdata,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    // command[1:0], handle[17:2], task_id[25:18], zero[31:26]
    input  logic [rrtq_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // status[1:0], running_valid[2], running_handle[18:3], assigned_id[26:19],
    // kill_handle[42:27], task_count[50:43], zero[55:51]
    input  logic [rrtq_pkg::M_TDATA_W-1:0] i_m_tdata,
    output int                             o_fail_count,
    output int                             o_outstanding
);

    rrtq_pkg::t_entry            ready_tasks[$];
    rrtq_pkg::t_result           predicted_reports[$];
    logic [rrtq_pkg::ID_W-1:0]   id_counter;
    logic                        kill_armed;
    int                          fail_count = 0;
    rrtq_pkg::t_result           got;
    rrtq_pkg::t_result           want;

    assign o_fail_count = fail_count;

    function automatic rrtq_pkg::t_result apply_command(
        rrtq_pkg::t_cmd cmd, logic [rrtq_pkg::HANDLE_W-1:0] h,
        logic [rrtq_pkg::ID_W-1:0] tid);
        rrtq_pkg::t_result r;
        rrtq_pkg::t_entry  e;
        int                hit;
        r        = '0;
        r.status = rrtq_pkg::ST_OK;
        case (cmd)
            rrtq_pkg::CMD_ADD: begin
                if (ready_tasks.size() >= DEPTH) begin
                    r.status = rrtq_pkg::ST_FULL;
                end else begin
                    r.assigned_id = id_counter;
                    e.handle      = h;
                    e.id          = id_counter;
                    ready_tasks.push_back(e);
                    id_counter = id_counter + 1'b1;
                end
            end
            rrtq_pkg::CMD_PREEMPT: begin
                if (ready_tasks.size() == 0) begin
                    r.status = rrtq_pkg::ST_EMPTY;
                end else begin
                    e = ready_tasks.pop_front();
                    ready_tasks.push_back(e);
                end
            end
            rrtq_pkg::CMD_EXIT: begin
                if (ready_tasks.size() == 0) begin
                    r.status = rrtq_pkg::ST_EMPTY;
                end else if (!kill_armed) begin
                    void'(ready_tasks.pop_front());
                end else begin
                    hit = -1;
                    for (int i = 0; i < ready_tasks.size(); i++) begin
                        if (ready_tasks[i].handle == h) begin
                            hit = i;
                            break;
                        end
                    end
                    if (hit < 0) begin
                        r.status = rrtq_pkg::ST_NOTFOUND;
                    end else begin
                        // entries ahead of the victim rotate to the back in order
                        repeat (hit) begin
                            e = ready_tasks.pop_front();
                            ready_tasks.push_back(e);
                        end
                        void'(ready_tasks.pop_front());
                    end
                    kill_armed = 1'b0;
                end
            end
            default: begin
                hit = -1;
                foreach (ready_tasks[i]) begin
                    if (ready_tasks[i].id == tid) begin
                        hit           = i;
                        r.kill_handle = ready_tasks[i].handle;
                    end
                end
                if (hit < 0) begin
                    r.status = rrtq_pkg::ST_NOTFOUND;
                end else begin
                    kill_armed = 1'b1;
                end
            end
        endcase
        r.running_valid  = (ready_tasks.size() > 0);
        r.running_handle = (ready_tasks.size() > 0) ? ready_tasks[0].handle : '0;
        r.task_count     = 8'(ready_tasks.size());
        return r;
    endfunction

    task automatic check_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ready_tasks.delete();
            predicted_reports.delete();
            id_counter = rrtq_pkg::FIRST_ID_RESET;
            kill_armed = 1'b0;
        end else begin
            if (i_cfg_we) begin
                id_counter = i_cfg_wdata;
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[$bits(rrtq_pkg::t_result)-1:0];
                if (predicted_reports.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    fail_count++;
                end else begin
                    want = predicted_reports.pop_front();
                    check_field("status", 16'(want.status), 16'(got.status));
                    check_field("running_valid", 16'(want.running_valid),
                                16'(got.running_valid));
                    check_field("running_handle", want.running_handle, got.running_handle);
                    check_field("assigned_id", 16'(want.assigned_id), 16'(got.assigned_id));
                    check_field("kill_handle", want.kill_handle, got.kill_handle);
                    check_field("task_count", 16'(want.task_count), 16'(got.task_count));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predicted_reports.push_back(apply_command(
                    rrtq_pkg::t_cmd'(i_s_tdata[1:0]), i_s_tdata[17:2], i_s_tdata[25:18]));
            end
        end
        o_outstanding <= predicted_reports.size();
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_cfg_we      = 1'b0;
    logic [rrtq_pkg::ID_W-1:0]      i_cfg_wdata   = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    // command[1:0], handle[17:2], task_id[25:18], zero[31:26]
    logic [rrtq_pkg::S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // status[1:0], running_valid[2], running_handle[18:3], assigned_id[26:19],
    // kill_handle[42:27], task_count[50:43], zero[55:51]
    logic [rrtq_pkg::M_TDATA_W-1:0] m_axis_tdata;

    int                        fail_count;
    int                        outstanding;
    int                        src_idle    = 0;
    int                        snk_idle    = 0;
    int                        stuck       = 0;
    int                        hold_left   = 0;
    logic                      hold_toggle = 1'b0;
    logic                      hold_seen   = 1'b0;
    int                        items_sent  = 0;
    int                        adds_sent   = 0;
    logic [rrtq_pkg::ID_W-1:0] id_base     = rrtq_pkg::FIRST_ID_RESET;
    logic [15:0]               handle_pool[8];

    round_robin_task_queue_core #(
        .QUEUE_DEPTH(rrtq_pkg::DEFAULT_QUEUE_DEPTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    task_queue_checker #(
        .DEPTH(rrtq_pkg::DEFAULT_QUEUE_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: random back-pressure, plus a long hold-off on request
    always @(posedge i_clk) begin
        hold_seen <= hold_toggle;
        if (hold_toggle != hold_seen) begin
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= snk_idle);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stuck <= 0;
        end else if (stuck == WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            stuck <= stuck + 1;
        end
    end

    function automatic logic [rrtq_pkg::S_TDATA_W-1:0] pack_command(
        rrtq_pkg::t_cmd cmd, logic [15:0] h, logic [rrtq_pkg::ID_W-1:0] tid);
        return {6'b0, tid, h, cmd};
    endfunction

    function automatic logic [15:0] pick_handle();
        if ($urandom_range(99) < 70) begin
            return handle_pool[$urandom_range(7)];
        end
        return 16'($urandom_range(16'hFFFF));
    endfunction

    task automatic send(rrtq_pkg::t_cmd cmd, logic [15:0] h,
                        logic [rrtq_pkg::ID_W-1:0] tid);
        if ($urandom_range(99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < src_idle) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_command(cmd, h, tid);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        if (cmd == rrtq_pkg::CMD_ADD) begin
            adds_sent++;
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic load_first_id(logic [rrtq_pkg::ID_W-1:0] value);
        drain();
        repeat (8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        id_base   = value;
        adds_sent = 0;
    endtask

    task automatic send_random(int add_w, int exit_w);
        int                        r;
        rrtq_pkg::t_cmd            cmd;
        logic [rrtq_pkg::ID_W-1:0] tid;
        r = $urandom_range(99);
        if (r < add_w) begin
            cmd = rrtq_pkg::CMD_ADD;
        end else if (r < add_w + exit_w) begin
            cmd = rrtq_pkg::CMD_EXIT;
        end else if ($urandom_range(1)) begin
            cmd = rrtq_pkg::CMD_PREEMPT;
        end else begin
            cmd = rrtq_pkg::CMD_KILL;
        end
        // kill ids mostly fall in the range handed out since the last id load
        if ($urandom_range(99) < 70) begin
            tid = 8'(id_base + $urandom_range(adds_sent));
        end else begin
            tid = 8'($urandom_range(255));
        end
        send(cmd, pick_handle(), tid);
        if (cmd == rrtq_pkg::CMD_KILL && $urandom_range(99) < 60) begin
            send(rrtq_pkg::CMD_EXIT, pick_handle(), 8'($urandom_range(255)));
        end
    endtask

    task automatic run_burst(int n, int add_w, int exit_w);
        int target;
        target = items_sent + n;
        while (items_sent < target) send_random(add_w, exit_w);
    endtask

    // fill to full, churn, then drain with mostly exit commands
    task automatic run_phase(logic [rrtq_pkg::ID_W-1:0] first_id, bit with_hold);
        load_first_id(first_id);
        if (with_hold) begin
            hold_toggle <= ~hold_toggle;
        end
        run_burst(150, 95, 2);
        run_burst(60, 30, 25);
        run_burst(160, 5, 70);
    endtask

    initial begin
        handle_pool[0] = 16'h0000;
        handle_pool[1] = 16'hFFFF;
        for (int i = 2; i < 8; i++) begin
            handle_pool[i] = 16'($urandom_range(16'hFFFF));
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        load_first_id(8'd254);
        send(rrtq_pkg::CMD_PREEMPT, 16'h0000, 8'h00);
        send(rrtq_pkg::CMD_EXIT, 16'hFFFF, 8'h00);
        send(rrtq_pkg::CMD_KILL, 16'h0000, 8'h00);
        send(rrtq_pkg::CMD_ADD, 16'h0000, 8'hFF);
        send(rrtq_pkg::CMD_PREEMPT, 16'h0000, 8'h00);
        send(rrtq_pkg::CMD_ADD, 16'hFFFF, 8'h00);
        send(rrtq_pkg::CMD_ADD, 16'h1234, 8'h00);
        send(rrtq_pkg::CMD_PREEMPT, 16'h0000, 8'h00);
        send(rrtq_pkg::CMD_KILL, 16'h0000, 8'hFF);
        send(rrtq_pkg::CMD_KILL, 16'h0000, 8'hFF);
        send(rrtq_pkg::CMD_EXIT, 16'hFFFF, 8'h00);
        send(rrtq_pkg::CMD_KILL, 16'h0000, 8'hAB);
        send(rrtq_pkg::CMD_EXIT, 16'h0000, 8'h00);
        load_first_id(8'd7);
        send(rrtq_pkg::CMD_ADD, 16'hBEEF, 8'h00);
        load_first_id(8'd7);
        send(rrtq_pkg::CMD_ADD, 16'hCAFE, 8'h55);
        send(rrtq_pkg::CMD_KILL, 16'h0000, 8'h07);
        send(rrtq_pkg::CMD_EXIT, 16'h5555, 8'h00);
        send(rrtq_pkg::CMD_PREEMPT, 16'h0000, 8'h00);
        send(rrtq_pkg::CMD_EXIT, 16'h0000, 8'h00);
        send(rrtq_pkg::CMD_EXIT, 16'h0000, 8'h00);
        send(rrtq_pkg::CMD_EXIT, 16'h0000, 8'h00);
        send(rrtq_pkg::CMD_EXIT, 16'h0000, 8'h00);

        src_idle = 32;
        snk_idle = 73;
        run_phase(8'd0, 1'b0);
        src_idle = 73;
        snk_idle = 32;
        run_phase(8'd255, 1'b0);
        src_idle = 0;
        snk_idle = 0;
        run_phase(8'($urandom_range(255)), 1'b1);

        drain();
        repeat (150) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### round_robin_task_queue_core.f
rtl/rrtq_pkg.sv
rtl/rrtq_mem.sv
rtl/rrtq_ctrl.sv
rtl/round_robin_task_queue_core.sv
bench/task_queue_checker.sv
bench/testbench.sv
